// ----- hdl/mono_page_framebuffer_defines.svh -----
// assertion macros shared by the frame buffer rtl
`ifndef MONO_PAGE_FRAMEBUFFER_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DEFINES_SVH

// same-cycle implication
`define MPFB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mpfb_pkg.sv -----
`timescale 1ns / 1ps
package mpfb_pkg;

   typedef enum logic [1:0] {
      FUNC_POINT = 2'd0,
      FUNC_FILL  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // what one byte step does to the store
   typedef enum logic [1:0] {
      STEP_NOP,
      STEP_RMW,
      STEP_ZERO,
      STEP_READ
   } step_kind_type;

   typedef struct packed {
      logic          valid;
      step_kind_type kind;
      logic [7:0]    mask;
      logic          lit;
      logic          last;
      logic          respond;
      logic          is_read;
   } step_type;

   localparam int         ROWS_PER_PAGE = 8;
   localparam logic [7:0] FULL_MASK     = 8'hFF;
   localparam logic [7:0] TOP_BIT_MASK  = 8'h80;
   localparam logic [7:0] ZERO_BYTE     = 8'h00;

endpackage

// ----- hdl/mono_page_framebuffer.sv -----
`timescale 1ns / 1ps
// monochrome page frame buffer, PANEL_WIDTH columns by 8*PANEL_PAGES rows
// request: an operation transfers at a clock edge with start high and busy low;
//   req_func selects draw point, fill rectangle, clear all or read byte
// response: every operation returns exactly one transfer, rsp_strobe high for
//   one cycle; rsp_read_valid marks a byte read, rsp_read_data is zero otherwise
// the store is one synchronous ram of bytes addressed {page, column}; point and
//   fill byte writes are read-modify-write, the write in the cycle after its read,
//   and clear writes zeros with no read; busy is high while steps are issued
// point or read: a single byte step; the next request is taken before
//   its response; fill: one step per byte touched (columns x pages covered),
//   with the response after the last byte; an empty or off-panel rectangle
//   costs like a point; clear all: sweeps every ram word, one step each
// reset: the same sweep runs after reset with busy high and no response
//   (1024 words at 128x64)
// the receiver cannot stall: a response is gone after its cycle
module mono_page_framebuffer import mpfb_pkg::*; #(
   parameter int PANEL_WIDTH = 128,
   parameter int PANEL_PAGES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_x_first,
   input  logic [7:0] req_y_first,
   input  logic [7:0] req_x_last,
   input  logic [7:0] req_y_last,
   input  logic       req_dot,
   input  logic [2:0] req_page_sel,
   input  logic [6:0] req_column_sel,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid
);

`include "mono_page_framebuffer_defines.svh"

   localparam int CW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
   localparam int PW = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
   localparam int AW = PW + CW;

   step_type      step;
   logic [AW-1:0] step_addr;

   // second stage: the read data of the step issued last cycle
   step_type      s1_step_ff;
   logic [AW-1:0] s1_addr_ff;

   logic          mem_we, mem_re;
   logic [7:0]    mem_wdata, mem_rdata;

   logic          rsp_strobe_ff;
   logic [7:0]    rsp_read_data_ff;
   logic          rsp_read_valid_ff;

   // sequencer turns each operation into byte steps
   mpfb_seq #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_PAGES (PANEL_PAGES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .func       (req_func),
      .x_first    (req_x_first),
      .y_first    (req_y_first),
      .x_last     (req_x_last),
      .y_last     (req_y_last),
      .dot        (req_dot),
      .page_sel   (req_page_sel),
      .column_sel (req_column_sel),
      .step       (step),
      .step_addr  (step_addr)
   );

   // read for modify and for byte reads
   assign mem_re = step.valid && ((step.kind == STEP_RMW) || (step.kind == STEP_READ));

   // write back in the cycle after the step; addresses within a walk never repeat
   assign mem_we = s1_step_ff.valid &&
                   ((s1_step_ff.kind == STEP_RMW) || (s1_step_ff.kind == STEP_ZERO));

   always_comb begin
      if (s1_step_ff.kind == STEP_ZERO) begin
         mem_wdata = ZERO_BYTE;
      end else if (s1_step_ff.lit) begin
         mem_wdata = mem_rdata | s1_step_ff.mask;
      end else begin
         mem_wdata = mem_rdata & ~s1_step_ff.mask;
      end
   end

   mpfb_store #(
      .ADDR_WIDTH (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (s1_addr_ff),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (step_addr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_step_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_step_ff    <= step;
         rsp_strobe_ff <= s1_step_ff.valid && s1_step_ff.last && s1_step_ff.respond;
      end
      s1_addr_ff        <= step_addr;
      rsp_read_data_ff  <= (s1_step_ff.kind == STEP_READ) ? mem_rdata : ZERO_BYTE;
      rsp_read_valid_ff <= s1_step_ff.valid && s1_step_ff.is_read;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_read_valid = rsp_read_valid_ff && rsp_strobe_ff;

   // write-back never hits the address being read in the same cycle
   `MPFB_ASSERT_IMP(a_no_rw_overlap, clock, reset, mem_we && mem_re,
                    s1_addr_ff != step_addr, "write-back collides with a read")
   // an accepted request raises busy in the next cycle
   `MPFB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                     "busy not raised after a request transfer")
   // a response comes only from the final step of an operation
   `MPFB_ASSERT_IMP(a_rsp_source, clock, reset, rsp_strobe,
                    $past(s1_step_ff.valid && s1_step_ff.last && s1_step_ff.respond),
                    "response without a final step")
   // responses never fall in two adjacent cycles
   `MPFB_ASSERT_IMP(a_rsp_one_cycle, clock, reset, rsp_strobe, !$past(rsp_strobe),
                    "response held for more than one cycle")

endmodule

// ----- hdl/mpfb_store.sv -----
`timescale 1ns / 1ps
module mpfb_store #(
   parameter int ADDR_WIDTH = 10
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_WIDTH-1:0] waddr,
   input  logic [7:0]            wdata,
   input  logic                  re,
   input  logic [ADDR_WIDTH-1:0] raddr,
   output logic [7:0]            rdata
);

   logic [7:0] mem [2**ADDR_WIDTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/mpfb_seq.sv -----
`timescale 1ns / 1ps
module mpfb_seq import mpfb_pkg::*; #(
   parameter int PANEL_WIDTH = 128,
   parameter int PANEL_PAGES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             func,
   input  logic [7:0]             x_first,
   input  logic [7:0]             y_first,
   input  logic [7:0]             x_last,
   input  logic [7:0]             y_last,
   input  logic                   dot,
   input  logic [2:0]             page_sel,
   input  logic [6:0]             column_sel,
   output step_type               step,
   output logic [(((PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1)
                 + ((PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1))-1:0] step_addr
);

   localparam int CW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
   localparam int PW = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
   localparam int AW = PW + CW;
   localparam logic [8:0] LAST_COL  = 9'(PANEL_WIDTH - 1);
   localparam logic [8:0] LAST_ROW  = 9'(ROWS_PER_PAGE * PANEL_PAGES - 1);
   localparam logic [4:0] LAST_PAGE = 5'(PANEL_PAGES - 1);

   typedef enum logic [1:0] {S_IDLE, S_ONE, S_FILL, S_SWEEP} state_type;

   state_type     state_ff;
   step_kind_type one_kind_ff;
   logic [AW-1:0] one_addr_ff;
   logic [7:0]    one_mask_ff;
   logic          one_read_ff;
   logic          lit_ff;
   logic [CW-1:0] col_ff, col_first_ff, col_last_ff;
   logic [PW-1:0] blk_ff, blk_first_ff, blk_last_ff;
   logic [2:0]    lo_ff, hi_ff;
   logic [AW-1:0] sweep_ff;
   logic          respond_ff;

   logic [8:0]    x1c, y1c;
   logic          fill_empty, pt_on, rd_on;
   logic [4:0]    pt_page;
   logic [AW-1:0] pt_addr, rd_addr;
   logic [PW-1:0] fill_page;
   logic [2:0]    fill_lo, fill_hi;
   logic [7:0]    fill_mask;
   logic          fill_last_col, fill_last_blk;

   // clip the far corner, then test for an empty rectangle
   assign x1c = ({1'b0, x_last} > LAST_COL) ? LAST_COL : {1'b0, x_last};
   assign y1c = ({1'b0, y_last} > LAST_ROW) ? LAST_ROW : {1'b0, y_last};
   assign fill_empty = ({1'b0, x_first} > x1c) || ({1'b0, y_first} > y1c);

   assign pt_on   = ({1'b0, x_first} <= LAST_COL) && ({1'b0, y_first} <= LAST_ROW);
   assign pt_page = LAST_PAGE - y_first[7:3];
   assign pt_addr = {pt_page[PW-1:0], CW'(x_first)};

   assign rd_on   = ({2'b00, page_sel} <= LAST_PAGE) && ({2'b00, column_sel} <= LAST_COL);
   assign rd_addr = {PW'(page_sel), CW'(column_sel)};

   // row band inside the current page
   assign fill_page     = PW'(LAST_PAGE) - blk_ff;
   assign fill_lo       = (blk_ff == blk_first_ff) ? lo_ff : 3'd0;
   assign fill_hi       = (blk_ff == blk_last_ff) ? hi_ff : 3'd7;
   assign fill_mask     = (FULL_MASK >> fill_lo) & (FULL_MASK << (3'd7 - fill_hi));
   assign fill_last_col = (col_ff == col_last_ff);
   assign fill_last_blk = (blk_ff == blk_last_ff);

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      step      = '0;
      step_addr = '0;
      unique case (state_ff)
         S_IDLE: begin
            step.valid = 1'b0;
         end
         S_ONE: begin
            step.valid   = 1'b1;
            step.kind    = one_kind_ff;
            step.mask    = one_mask_ff;
            step.lit     = lit_ff;
            step.last    = 1'b1;
            step.respond = 1'b1;
            step.is_read = one_read_ff;
            step_addr    = one_addr_ff;
         end
         S_FILL: begin
            step.valid   = 1'b1;
            step.kind    = STEP_RMW;
            step.mask    = fill_mask;
            step.lit     = lit_ff;
            step.last    = fill_last_col && fill_last_blk;
            step.respond = 1'b1;
            step_addr    = {fill_page, col_ff};
         end
         S_SWEEP: begin
            step.valid   = 1'b1;
            step.kind    = STEP_ZERO;
            step.last    = &sweep_ff;
            step.respond = respond_ff;
            step_addr    = sweep_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_SWEEP;
         sweep_ff   <= '0;
         respond_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  lit_ff      <= dot;
                  one_mask_ff <= TOP_BIT_MASK >> y_first[2:0];
                  unique case (func_type'(func))
                     FUNC_POINT: begin
                        one_kind_ff <= pt_on ? STEP_RMW : STEP_NOP;
                        one_addr_ff <= pt_addr;
                        one_read_ff <= 1'b0;
                        state_ff    <= S_ONE;
                     end
                     FUNC_FILL: begin
                        one_kind_ff  <= STEP_NOP;
                        one_addr_ff  <= pt_addr;
                        one_read_ff  <= 1'b0;
                        col_ff       <= CW'(x_first);
                        col_first_ff <= CW'(x_first);
                        col_last_ff  <= CW'(x1c);
                        blk_ff       <= PW'(y_first[7:3]);
                        blk_first_ff <= PW'(y_first[7:3]);
                        blk_last_ff  <= PW'(y1c[8:3]);
                        lo_ff        <= y_first[2:0];
                        hi_ff        <= y1c[2:0];
                        state_ff     <= fill_empty ? S_ONE : S_FILL;
                     end
                     FUNC_CLEAR: begin
                        sweep_ff   <= '0;
                        respond_ff <= 1'b1;
                        state_ff   <= S_SWEEP;
                     end
                     FUNC_READ: begin
                        one_kind_ff <= rd_on ? STEP_READ : STEP_NOP;
                        one_addr_ff <= rd_addr;
                        one_read_ff <= 1'b1;
                        state_ff    <= S_ONE;
                     end
                  endcase
               end
            end
            S_ONE: begin
               state_ff <= S_IDLE;
            end
            S_FILL: begin
               if (fill_last_col) begin
                  col_ff <= col_first_ff;
                  if (fill_last_blk) begin
                     state_ff <= S_IDLE;
                  end else begin
                     blk_ff <= blk_ff + 1'b1;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (&sweep_ff) begin
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule

// ----- tb/mono_page_framebuffer_checker.sv -----
`timescale 1ns / 1ps
// watches both channels, keeps a shadow frame and checks every response in order
module mono_page_framebuffer_checker import mpfb_pkg::*; #(
   parameter int PANEL_WIDTH = 128,
   parameter int PANEL_PAGES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_x_first,
   input  logic [7:0] req_y_first,
   input  logic [7:0] req_x_last,
   input  logic [7:0] req_y_last,
   input  logic       req_dot,
   input  logic [2:0] req_page_sel,
   input  logic [6:0] req_column_sel,
   input  logic       rsp_strobe,
   input  logic [7:0] rsp_read_data,
   input  logic       rsp_read_valid,
   output int         fail_count,
   output int         outstanding
);

   localparam int PANEL_ROWS = PANEL_PAGES * ROWS_PER_PAGE;
   localparam int FRAME_BYTES = PANEL_WIDTH * PANEL_PAGES;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
   } reply_type;

   logic [7:0] shadow_frame [FRAME_BYTES];
   reply_type  owed_replies [$];
   int         mismatches;

   assign fail_count = mismatches;

   function automatic void paint_pixel(input int x, input int y, input logic lit);
      int page;
      int idx;
      logic [7:0] mask;
      if (x >= PANEL_WIDTH || y >= PANEL_ROWS) return;
      page = PANEL_PAGES - 1 - y / ROWS_PER_PAGE;
      mask = TOP_BIT_MASK >> (y % ROWS_PER_PAGE);
      idx = page * PANEL_WIDTH + x;
      if (lit) shadow_frame[idx] = shadow_frame[idx] | mask;
      else shadow_frame[idx] = shadow_frame[idx] & ~mask;
   endfunction

   // updates the shadow frame for one operation and returns its response
   function automatic reply_type apply_to_frame(
      input func_type   op,
      input logic [7:0] xf,
      input logic [7:0] yf,
      input logic [7:0] xl,
      input logic [7:0] yl,
      input logic       lit,
      input logic [2:0] pg,
      input logic [6:0] col
   );
      reply_type r;
      int x0, y0, x1, y1;
      r = '{data: ZERO_BYTE, valid: 1'b0};
      x0 = int'(xf); y0 = int'(yf); x1 = int'(xl); y1 = int'(yl);
      case (op)
         FUNC_POINT: paint_pixel(x0, y0, lit);
         FUNC_FILL: begin
            if (x0 <= x1 && y0 <= y1) begin
               if (x1 > PANEL_WIDTH - 1) x1 = PANEL_WIDTH - 1;
               if (y1 > PANEL_ROWS - 1) y1 = PANEL_ROWS - 1;
               if (x0 <= x1 && y0 <= y1) begin
                  for (int x = x0; x <= x1; x++)
                     for (int y = y0; y <= y1; y++)
                        paint_pixel(x, y, lit);
               end
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < FRAME_BYTES; i++) shadow_frame[i] = ZERO_BYTE;
         end
         default: begin
            r.valid = 1'b1;
            if (int'(pg) < PANEL_PAGES && int'(col) < PANEL_WIDTH)
               r.data = shadow_frame[int'(pg) * PANEL_WIDTH + int'(col)];
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type oldest;
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) shadow_frame[i] = ZERO_BYTE;
         owed_replies.delete();
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_replies.size() == 0) begin
               $error("response with none owed: read_data %h read_valid %b",
                      rsp_read_data, rsp_read_valid);
               mismatches++;
            end else begin
               oldest = owed_replies.pop_front();
               if (rsp_read_data !== oldest.data) begin
                  $error("read_data: expected %h, actual %h", oldest.data, rsp_read_data);
                  mismatches++;
               end
               if (rsp_read_valid !== oldest.valid) begin
                  $error("read_valid: expected %b, actual %b", oldest.valid, rsp_read_valid);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            owed_replies.push_back(apply_to_frame(func_type'(req_func), req_x_first,
               req_y_first, req_x_last, req_y_last, req_dot, req_page_sel, req_column_sel));
         outstanding <= owed_replies.size();
      end
   end

endmodule

// ----- tb/mono_page_framebuffer_tb.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the page frame buffer; checking lives in the checker
module mono_page_framebuffer_tb import mpfb_pkg::*;;

   localparam int PANEL_WIDTH = 128;
   localparam int PANEL_PAGES = 8;
   localparam int RANDOM_ITEMS = 1850;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_func;
   logic [7:0] req_x_first;
   logic [7:0] req_y_first;
   logic [7:0] req_x_last;
   logic [7:0] req_y_last;
   logic       req_dot;
   logic [2:0] req_page_sel;
   logic [6:0] req_column_sel;
   logic       rsp_strobe;
   logic [7:0] rsp_read_data;
   logic       rsp_read_valid;
   int         fail_count;
   int         outstanding;

   mono_page_framebuffer #(
      .PANEL_WIDTH(PANEL_WIDTH),
      .PANEL_PAGES(PANEL_PAGES)
   ) dut (.*);

   mono_page_framebuffer_checker #(
      .PANEL_WIDTH(PANEL_WIDTH),
      .PANEL_PAGES(PANEL_PAGES)
   ) checker_i (.*);

   // 20 ns period, first rising edge at 10 ns
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // one transfer: present the request and hold it until busy is low at an edge;
   // start is left high so a back-to-back follower needs no second assignment
   task automatic issue_op(
      input logic [1:0] f,
      input logic [7:0] xf,
      input logic [7:0] yf,
      input logic [7:0] xl,
      input logic [7:0] yl,
      input logic       d,
      input logic [2:0] pg,
      input logic [6:0] col
   );
      start          <= 1'b1;
      req_func       <= f;
      req_x_first    <= xf;
      req_y_first    <= yf;
      req_x_last     <= xl;
      req_y_last     <= yl;
      req_dot        <= d;
      req_page_sel   <= pg;
      req_column_sel <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // lower start and sit until every owed response has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one random operation; fields the operation ignores carry random noise
   task automatic issue_random_op();
      int pick;
      int shape;
      logic [1:0] f;
      logic [7:0] xf, yf, xl, yl;
      logic d;
      logic [2:0] pg;
      logic [6:0] col;
      pick = $urandom_range(0, 999);
      xf = 8'($urandom); yf = 8'($urandom); xl = 8'($urandom); yl = 8'($urandom);
      d = 1'($urandom); pg = 3'($urandom); col = 7'($urandom);
      if (pick < 350) begin
         // mostly on-panel points, some anywhere in the byte range
         f = FUNC_POINT;
         if ($urandom_range(0, 99) < 85) begin
            xf = 8'($urandom_range(0, PANEL_WIDTH - 1));
            yf = 8'($urandom_range(0, PANEL_PAGES * ROWS_PER_PAGE - 1));
         end
         d = ($urandom_range(0, 99) < 70);
      end else if (pick < 570) begin
         f = FUNC_FILL;
         shape = $urandom_range(0, 99);
         if (shape < 90) begin
            // small rectangles, the far corner may spill past the edge
            xf = 8'($urandom_range(0, PANEL_WIDTH - 1));
            yf = 8'($urandom_range(0, PANEL_PAGES * ROWS_PER_PAGE - 1));
            xl = 8'(xf + $urandom_range(0, 15));
            yl = 8'(yf + $urandom_range(0, 15));
         end else if (shape < 96) begin
            // corners anywhere: often empty or off panel
            xf = 8'($urandom); yf = 8'($urandom); xl = 8'($urandom); yl = 8'($urandom);
         end else begin
            // nearly the whole panel, up to the byte-range corner
            xf = 8'($urandom_range(0, 20));
            yf = 8'($urandom_range(0, 10));
            xl = 8'($urandom_range(100, 255));
            yl = 8'($urandom_range(50, 255));
         end
         d = ($urandom_range(0, 99) < 60);
      end else if (pick < 985) begin
         f = FUNC_READ;
      end else begin
         f = FUNC_CLEAR;
      end
      issue_op(f, xf, yf, xl, yl, d, pg, col);
   endtask

   initial begin : stimulus
      int issued;
      int burst;
      int gap;
      int next_drain;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= FUNC_POINT;
      req_x_first    <= '0;
      req_y_first    <= '0;
      req_x_last     <= '0;
      req_y_last     <= '0;
      req_dot        <= 1'b0;
      req_page_sel   <= '0;
      req_column_sel <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, off-panel points, clipping, empty rectangles, clear
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd0, 7'd0);
      issue_op(FUNC_POINT, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 3'd0, 7'd0);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd7, 7'd0);
      issue_op(FUNC_POINT, 8'd127, 8'd63,  8'd255, 8'd255, 1'b1, 3'd7, 7'd127);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd0, 7'd127);
      // points just off the right and bottom edges, and the far byte corner
      issue_op(FUNC_POINT, 8'd128, 8'd0,   8'd0,   8'd0,   1'b1, 3'd0, 7'd0);
      issue_op(FUNC_POINT, 8'd0,   8'd64,  8'd0,   8'd0,   1'b1, 3'd0, 7'd0);
      issue_op(FUNC_POINT, 8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 3'd0, 7'd0);
      issue_op(FUNC_POINT, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd0, 7'd0);
      issue_op(FUNC_READ,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 3'd7, 7'd0);
      // whole panel lit through a far corner of 255, then a read back
      issue_op(FUNC_FILL,  8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 3'd0, 7'd0);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd3, 7'd64);
      // empty in x, empty in y, starting right of and below the panel
      issue_op(FUNC_FILL,  8'd10,  8'd0,   8'd5,   8'd5,   1'b0, 3'd0, 7'd0);
      issue_op(FUNC_FILL,  8'd0,   8'd9,   8'd5,   8'd3,   1'b0, 3'd0, 7'd0);
      issue_op(FUNC_FILL,  8'd130, 8'd0,   8'd200, 8'd10,  1'b0, 3'd0, 7'd0);
      issue_op(FUNC_FILL,  8'd0,   8'd70,  8'd10,  8'd80,  1'b0, 3'd0, 7'd0);
      // a dark patch that straddles a page boundary
      issue_op(FUNC_FILL,  8'd3,   8'd5,   8'd9,   8'd12,  1'b0, 3'd0, 7'd0);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd7, 7'd5);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd6, 7'd5);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd0, 7'd127);
      issue_op(FUNC_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd0, 7'd0);
      issue_op(FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 3'd3, 7'd64);
      drain_responses();

      // random: bursts of transfers with random gaps, now and then a long
      // unbroken stretch, and a full drain every few hundred items
      issued = 0;
      next_drain = 400;
      while (issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) burst = $urandom_range(40, 80);
         else burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && issued < RANDOM_ITEMS; i++) begin
            issue_random_op();
            issued++;
         end
         if (issued >= next_drain) begin
            drain_responses();
            next_drain += 400;
         end else begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // wait out the last response, then a few more cycles for strays
      drain_responses();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard limit, far beyond the slowest legal run
   initial begin : watchdog
      #200_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
